// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication on every rising clock edge outside of reset.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that a condition never holds on a rising clock edge outside of reset.
`define ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/itbd_pkg.sv =====
package itbd_pkg;

  // Width of the converted value and of the digit bookkeeping.
  localparam int VALUE_BITS = 31;
  localparam int CNT_W      = $clog2(VALUE_BITS);
  localparam int DIGIT_W    = 6;
  localparam int CHAR_W     = 7;
  localparam int RADIX_W    = 6;

  // Stream word widths, padded to whole bytes.
  localparam int S_TDATA_W = ((VALUE_BITS + 7) / 8) * 8;
  localparam int M_TDATA_W = ((CHAR_W + 7) / 8) * 8;

  // Radix limits and reset value.
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

  // ASCII anchors for the digit characters.
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_NINE  = CHAR_W'(57);
  localparam logic [CHAR_W-1:0] CHAR_LOW_A = CHAR_W'(97);
  localparam logic [CHAR_W-1:0] CHAR_LOW_Z = CHAR_W'(122);
  localparam logic [DIGIT_W-1:0] DEC_DIGITS = DIGIT_W'(10);

  // Result of one division pass.
  typedef struct packed {
    logic                  done;
    logic [VALUE_BITS-1:0] quotient;
    logic [DIGIT_W-1:0]    remainder;
  } div_rsp_t;

  // Maps a digit value to its lower-case ASCII character.
  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dw;
    dw = {{(CHAR_W - DIGIT_W){1'b0}}, d};
    if (d < DEC_DIGITS) begin
      return dw + CHAR_ZERO;
    end else begin
      return dw - {{(CHAR_W - DIGIT_W){1'b0}}, DEC_DIGITS} + CHAR_LOW_A;
    end
  endfunction

endpackage

// ===== hw/rtl/itbd_divider.sv =====
module itbd_divider (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [itbd_pkg::VALUE_BITS-1:0] dividend,
  input  logic [itbd_pkg::RADIX_W-1:0]    divisor,
  output itbd_pkg::div_rsp_t             rsp
);
  import itbd_pkg::*;

  logic                  busy;
  logic                  done;
  logic [CNT_W-1:0]      cnt;
  logic [VALUE_BITS-1:0] work;
  logic [DIGIT_W-1:0]    rem;

  logic [DIGIT_W:0]      rem_trial;
  logic                  fits;

  // One restoring step: bring down the next dividend bit and try the subtract.
  assign rem_trial = {rem, work[VALUE_BITS-1]};
  assign fits      = rem_trial >= {{(DIGIT_W + 1 - RADIX_W){1'b0}}, divisor};

  // Control: run one step per cycle until every dividend bit is consumed.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(VALUE_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + CNT_W'(1);
        end
      end
    end
  end

  // Datapath: quotient bits shift into the low end of the working register.
  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
    end else if (busy) begin
      work <= {work[VALUE_BITS-2:0], fits};
      if (fits) begin
        rem <= DIGIT_W'(rem_trial - {{(DIGIT_W + 1 - RADIX_W){1'b0}}, divisor});
      end else begin
        rem <= rem_trial[DIGIT_W-1:0];
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = work;
  assign rsp.remainder = rem;

endmodule

// ===== hw/rtl/itbd_digit_store.sv =====
module itbd_digit_store (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [itbd_pkg::CNT_W-1:0]   wr_addr,
  input  logic [itbd_pkg::DIGIT_W-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [itbd_pkg::CNT_W-1:0]   rd_addr,
  output logic [itbd_pkg::DIGIT_W-1:0] rd_data
);
  import itbd_pkg::*;

  logic [DIGIT_W-1:0] mem [VALUE_BITS];

  // Remainders are written as they come out of the divider.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, held until the next read request.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/integer_to_base_digits.sv =====
// Flow: an accepted word is divided down to zero, then the stored digits are sent.
// Each digit costs one bit-serial division pass through the shared divider, one cycle a bit.
// Output: digits leave most significant first, each held until the sink takes it.
// A new value is accepted only after the last digit of the previous one has been taken.
// Reset (rst, synchronous): radix returns to 10 and the sequencer returns to idle.
module integer_to_base_digits (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           radix_we,
  input  logic [itbd_pkg::RADIX_W-1:0]   radix_wdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [itbd_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [30:0] value, [31] zero
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [itbd_pkg::M_TDATA_W-1:0] m_axis_tdata,  // [6:0] digit_char, [7] zero
  output logic                           m_axis_tlast
);
  import itbd_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_WAIT = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]            state;
  logic [RADIX_W-1:0]    radix;
  logic [RADIX_W-1:0]    radix_eff;
  logic [VALUE_BITS-1:0] quot;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      rd_ptr;
  logic [DIGIT_W-1:0]    rd_data;
  div_rsp_t              div_rsp;

  // Radix register; out-of-range codes are clamped when used.
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (radix_we) begin
      radix <= radix_wdata;
    end
  end

  always_comb begin
    if (radix < RADIX_MIN) begin
      radix_eff = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      radix_eff = RADIX_MAX;
    end else begin
      radix_eff = radix;
    end
  end

  // Shared bit-serial divider, one pass per digit.
  itbd_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_DIV),
    .dividend (quot),
    .divisor  (radix_eff),
    .rsp      (div_rsp)
  );

  // Remainders go in least significant first and are read back in reverse.
  itbd_digit_store u_store (
    .clk     (clk),
    .wr_en   (state == ST_WAIT && div_rsp.done),
    .wr_addr (count),
    .wr_data (div_rsp.remainder),
    .rd_en   (state == ST_RD),
    .rd_addr (rd_ptr),
    .rd_data (rd_data)
  );

  // Sequencer: divide until the quotient is zero, then emit the stored digits.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      rd_ptr <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            count <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (div_rsp.done) begin
            count <= count + CNT_W'(1);
            if (div_rsp.quotient == '0) begin
              rd_ptr <= count;
              state  <= ST_RD;
            end else begin
              state <= ST_DIV;
            end
          end
        end
        ST_RD: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            if (rd_ptr == '0) begin
              state <= ST_IDLE;
            end else begin
              rd_ptr <= rd_ptr - CNT_W'(1);
              state  <= ST_RD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Running quotient: loaded from the input word, then from each division pass.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_axis_tvalid) begin
      quot <= s_axis_tdata[VALUE_BITS-1:0];
    end else if (state == ST_WAIT && div_rsp.done) begin
      quot <= div_rsp.quotient;
    end
  end

  // Stream handshakes and output word.
  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata  = {{(M_TDATA_W - CHAR_W){1'b0}}, digit_to_char(rd_data)};
  assign m_axis_tlast  = (rd_ptr == '0);

endmodule

// ===== hw/rtl/itbd_checker.sv =====
`include "assert_macros.svh"

module itbd_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [itbd_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tlast
);
  import itbd_pkg::*;

  logic               in_fire;
  logic               last_fire;
  logic               out_stall;
  logic               char_ok;
  logic [M_TDATA_W:0] out_word;

  // Handshake events and the word shown on the output side.
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign last_fire = m_axis_tvalid && m_axis_tready && m_axis_tlast;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_word  = {m_axis_tlast, m_axis_tdata};

  // A digit word is a decimal digit or a lower-case letter, padded with zeros.
  assign char_ok = (m_axis_tdata[M_TDATA_W-1:CHAR_W] == '0) &&
                   (m_axis_tdata[CHAR_W-1:0] inside {[CHAR_ZERO:CHAR_NINE],
                                                     [CHAR_LOW_A:CHAR_LOW_Z]});

  // The block works on one value at a time: never ready while a digit is shown.
  `ASSERT_NEVER(a_ready_while_emitting, s_axis_tready && m_axis_tvalid, "ready while emitting")

  // Once a value is taken, no other value is taken in the next cycle.
  `ASSERT_CLK(a_busy_after_accept, in_fire |=> !s_axis_tready, "ready right after accept")

  // The final digit hands control back to the input side.
  `ASSERT_CLK(a_idle_after_last, last_fire |=> s_axis_tready, "not idle after last digit")

  // Every digit word is a decimal digit or a lower-case letter.
  `ASSERT_CLK(a_char_range, m_axis_tvalid |-> char_ok, "digit out of range")

  // A stalled digit word holds.
  `ASSERT_CLK(a_out_hold, out_stall |=> m_axis_tvalid && $stable(out_word), "stalled word changed")

endmodule

bind integer_to_base_digits itbd_checker u_itbd_checker (.*);

// ===== test/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import itbd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned PHASE_ITEMS = 25;
  localparam int unsigned REPORT_LIMIT = 10;

  // One digit word as it should leave the block.
  typedef struct {
    logic [CHAR_W-1:0] digit_char;
    logic              last;
  } digit_word_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 radix_we = 1'b0;
  logic [RADIX_W-1:0]   radix_wdata = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tlast;

  // Digits still owed by the block, oldest first.
  digit_word_t pending_digits[$];

  // Radix as last written, used by the digit predictor.
  logic [RADIX_W-1:0] radix_setting = RADIX_RESET;

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          source_gaps_on = 1'b1;
  bit          sink_stalls_on = 1'b1;
  int unsigned stall_left = 0;

  integer_to_base_digits i_dut (
    .clk           (clk),
    .rst           (rst),
    .radix_we      (radix_we),
    .radix_wdata   (radix_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  // Gap length: mostly short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      return $urandom_range(1, 3);
    end else if (roll < 95) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 40);
  endfunction

  // Random value with a random magnitude, so short and long digit strings both show up.
  function automatic logic [VALUE_BITS-1:0] random_value();
    int unsigned           span;
    logic [VALUE_BITS-1:0] raw;
    span = $urandom_range(1, VALUE_BITS);
    raw = VALUE_BITS'($urandom);
    if ($urandom_range(0, 19) == 0) begin
      return '1;
    end
    return raw >> (VALUE_BITS - span);
  endfunction

  // Repeated division by the clamped radix; remainders come out least
  // significant first, so they are stacked in front to get the print order.
  function automatic void predict_digits(input logic [VALUE_BITS-1:0] value);
    logic [VALUE_BITS-1:0] quo;
    logic [VALUE_BITS-1:0] base;
    logic [DIGIT_W-1:0]    rem;
    digit_word_t           word;
    digit_word_t           digits[$];
    if (radix_setting < RADIX_MIN) begin
      base = VALUE_BITS'(RADIX_MIN);
    end else if (radix_setting > RADIX_MAX) begin
      base = VALUE_BITS'(RADIX_MAX);
    end else begin
      base = VALUE_BITS'(radix_setting);
    end
    quo = value;
    do begin
      rem = DIGIT_W'(quo % base);
      quo = quo / base;
      if (rem < DEC_DIGITS) begin
        word.digit_char = CHAR_W'(rem) + CHAR_ZERO;
      end else begin
        word.digit_char = CHAR_W'(rem) - CHAR_W'(DEC_DIGITS) + CHAR_LOW_A;
      end
      word.last = 1'b0;
      digits.push_front(word);
    end while (quo != 0);
    foreach (digits[i]) begin
      word = digits[i];
      word.last = (i == digits.size() - 1);
      pending_digits.push_back(word);
    end
  endfunction

  // Sends one value. Valid is left high after the handshake so that a
  // back-to-back word needs no second assignment in the same step.
  task automatic send_value(input logic [VALUE_BITS-1:0] value);
    int unsigned gap;
    gap = 0;
    if (source_gaps_on && $urandom_range(0, 2) == 0) begin
      gap = pick_gap();
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= S_TDATA_W'(value);
    do @(posedge clk); while (!s_axis_tready);
    predict_digits(value);
  endtask

  // Lets the block run dry and then writes the radix.
  task automatic set_radix(input logic [RADIX_W-1:0] radix);
    s_axis_tvalid <= 1'b0;
    wait (pending_digits.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    radix_we <= 1'b1;
    radix_wdata <= radix;
    @(posedge clk);
    radix_we <= 1'b0;
    radix_setting = radix;
  endtask

  // Decimal at the reset radix: zero, one digit, carry into two, full range.
  task automatic test_reset_radix();
    send_value(0);
    send_value(1);
    send_value(9);
    send_value(10);
    send_value('1);
  endtask

  // Binary gives the longest strings; alternating patterns toggle every bit.
  task automatic test_binary();
    set_radix(RADIX_W'(2));
    send_value(0);
    send_value(1);
    send_value('1);
    send_value(31'h55555555);
    send_value(31'h2aaaaaaa);
  endtask

  // Base 36 reaches the letter 'z' and the shortest long strings.
  task automatic test_base36();
    set_radix(RADIX_MAX);
    send_value(35);
    send_value(36);
    send_value(1295);
    send_value('1);
  endtask

  // Radix below two acts as two, above thirty-six acts as thirty-six.
  task automatic test_radix_clamping();
    set_radix(RADIX_W'(0));
    send_value(6);
    set_radix(RADIX_W'(1));
    send_value(6);
    set_radix(RADIX_W'(37));
    send_value(35);
    send_value(36);
    set_radix(RADIX_W'(63));
    send_value('1);
  endtask

  // Random values over a series of radix settings with varying idle patterns.
  task automatic test_random_values();
    logic [RADIX_W-1:0] radix;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: radix = RADIX_W'(2);
        1: radix = RADIX_MAX;
        2: radix = RADIX_W'(16);
        3: radix = RADIX_W'($urandom_range(0, 1));
        4: radix = RADIX_W'($urandom_range(37, 63));
        5: radix = RADIX_W'(8);
        6: radix = RADIX_W'($urandom_range(3, 35));
        default: radix = RADIX_W'($urandom);
      endcase
      set_radix(radix);
      source_gaps_on = (phase % 3 != 2);
      sink_stalls_on = (phase % 4 != 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_value(random_value());
      end
    end
    source_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
  endtask

  // Sink side: random stalls on the ready line.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (sink_stalls_on && $urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= pick_gap() - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare every accepted digit word with the oldest expected one.
  always @(posedge clk) begin
    digit_word_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_digits.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
          $display("Unexpected digit word: digit_char 0x%02h last %0b",
                   m_axis_tdata, m_axis_tlast);
        end
      end else begin
        want = pending_digits.pop_front();
        if (m_axis_tdata != M_TDATA_W'(want.digit_char) || m_axis_tlast != want.last) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) begin
            $display("Digit mismatch: char exp 0x%02h got 0x%02h, last exp %0b got %0b",
                     want.digit_char, m_axis_tdata, want.last, m_axis_tlast);
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_radix();
    test_binary();
    test_base36();
    test_radix_clamping();
    test_random_values();
    s_axis_tvalid <= 1'b0;
    wait (pending_digits.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/itbd_pkg.sv
hw/rtl/itbd_divider.sv
hw/rtl/itbd_digit_store.sv
hw/rtl/integer_to_base_digits.sv
hw/rtl/itbd_checker.sv
test/tb.sv
